// ----- hw/rtl/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap package
// Shared widths, codes, entry type and sequencer states for the heap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

    localparam int CAPACITY   = 1024;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int NODE_W     = 16;
    localparam int COST_W     = 30;
    localparam int KEY_W      = 31;
    localparam int STATUS_W   = 2;
    localparam int ENT_CNT_W  = 11;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 64;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_WAIT,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/binary_min_heap_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Open-list heap: insert by sift-up, remove-minimum by sift-down.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one operation per transfer. s_axis_tuser is
//   the operation (0 insert, 1 remove minimum); s_axis_tdata holds the node
//   id, cost-so-far and estimate used by an insert. The m_axis channel
//   returns exactly one result per operation: removed node, removed key,
//   status and the entry count after the operation.
//   One operation is processed at a time; s_axis_tready is high only while
//   the sequencer is idle. Each heap level takes one read of the dual-port
//   entry store and then one compare and write. Rejected operations (insert
//   while full, remove while empty) go straight from idle to the done state.
//   Reset empties the heap at once; the entry store itself is not cleared.
//   The result sits in an output register; if the receiver stalls, the next
//   operation may still be accepted and worked on, and it waits at its end
//   until the output register has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_priority_queue_unit
    import bmh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] node_id, [45:16] cost_so_far, [75:46] estimate, [79:76] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] removed_node, [46:16] removed_key, [48:47] status,
    // [59:49] entry_count, [63:60] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    t_entry                r_ent, n_ent;
    t_entry                r_res, n_res;
    t_status               r_status, n_status;
    logic                  r_m_tvalid, n_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    t_entry                mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr_a;
    logic [ADDR_W-1:0]     mem_raddr_b;
    t_entry                rd_a;
    t_entry                rd_b;

    logic                  in_xfer;
    logic [NODE_W-1:0]     in_node;
    logic [COST_W-1:0]     in_cost;
    logic [COST_W-1:0]     in_est;
    logic [KEY_W-1:0]      in_key;
    logic [ADDR_W-1:0]     parent;
    logic [COUNT_W-1:0]    left_cnt;
    logic [COUNT_W-1:0]    right_cnt;
    logic                  right_ok;
    logic                  pick_right;
    t_entry                pick_ent;
    logic [ADDR_W-1:0]     pick_addr;
    logic                  has_child;
    logic                  out_free;

    bmh_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_node       = s_axis_tdata[NODE_W-1:0];
    assign in_cost       = s_axis_tdata[NODE_W +: COST_W];
    assign in_est        = s_axis_tdata[NODE_W+COST_W +: COST_W];
    assign in_key        = KEY_W'(in_cost) + KEY_W'(in_est);

    assign parent     = (r_pos - ADDR_W'(1)) >> 1;
    assign left_cnt   = {r_pos, 1'b1};
    assign right_cnt  = left_cnt + COUNT_W'(1);
    assign right_ok   = right_cnt < r_count;
    assign has_child  = COUNT_W'(r_pos) < (r_count >> 1);
    // On equal child keys the left child wins.
    assign pick_right = right_ok && (rd_a.key > rd_b.key);
    assign pick_ent   = pick_right ? rd_b : rd_a;
    assign pick_addr  = pick_right ? right_cnt[ADDR_W-1:0] : left_cnt[ADDR_W-1:0];
    assign out_free   = !r_m_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_ent     <= n_ent;
        r_res     <= n_res;
        r_status  <= n_status;
        r_m_tdata <= n_m_tdata;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ent       = r_ent;
        n_res       = r_res;
        n_status    = r_status;
        n_m_tvalid  = r_m_tvalid;
        n_m_tdata   = r_m_tdata;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_ent;
        mem_raddr_a = left_cnt[ADDR_W-1:0];
        mem_raddr_b = right_cnt[ADDR_W-1:0];

        if (r_m_tvalid && m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // Root and last entry are fetched together for a remove.
                mem_raddr_a = '0;
                mem_raddr_b = ADDR_W'(r_count - COUNT_W'(1));
                n_res       = '0;
                n_status    = ST_OK;
                n_ent.key   = in_key;
                n_ent.node  = in_node;
                n_pos       = r_count[ADDR_W-1:0];
                if (in_xfer) begin
                    if (s_axis_tuser == OP_INSERT) begin
                        if (r_count == CAP_COUNT) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count + COUNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count - COUNT_W'(1);
                            n_state = S_RM_WAIT;
                        end
                    end
                end
            end
            S_UP_RD: begin
                mem_raddr_a = parent;
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (rd_a.key <= r_ent.key) begin
                    n_state = S_DONE;
                end else begin
                    mem_wdata = rd_a;
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end
            end
            S_RM_WAIT: begin
                n_res = rd_a;
                n_ent = rd_b;
                n_pos = '0;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (has_child) begin
                    n_state = S_DN_CMP;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_ent.key <= pick_ent.key) begin
                    n_state = S_DONE;
                end else begin
                    mem_wdata = pick_ent;
                    n_pos     = pick_addr;
                    n_state   = S_DN_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = OUT_DATA_W'({ENT_CNT_W'(r_count), r_status,
                                              r_res.key, r_res.node});
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // The heap never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("heap count beyond capacity");

    // An accepted insert into a heap with room grows it by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == OP_INSERT && r_count != CAP_COUNT)
        |=> r_count == $past(r_count) + COUNT_W'(1))
        else $error("insert did not grow the heap");

    // The sift-down position always lies inside the live part of the heap.
    a_sift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP) |-> (COUNT_W'(r_pos) < r_count))
        else $error("sift-down position outside heap");

    // The store is only written while an operation is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("entry store written while idle");

endmodule

`default_nettype wire

// ----- hw/rtl/bmh_mem.sv -----
// ----------------------------------------------------------------------------
// Heap entry store
// One write port and two registered read ports over the heap array.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmh_mem
    import bmh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  t_entry                 i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output t_entry                 o_rdata_a,
    output t_entry                 o_rdata_b
);

    t_entry r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
